>>> hdl/msie_pkg.sv
package msie_pkg;

    localparam int DATA_BYTES = 1024;
    localparam int ADDR_W     = $clog2(DATA_BYTES);
    localparam int ROWS       = DATA_BYTES / 4;
    localparam int ROW_W      = ADDR_W - 2;

    localparam int IN_RAW_W   = 2 + 32 + 8 + 32;
    localparam int IN_W       = (IN_RAW_W + 7) / 8 * 8;
    localparam int OUT_RAW_W  = 32 + 1 + 1 + 5 + 32 + 1 + ADDR_W + 32;
    localparam int OUT_W      = (OUT_RAW_W + 7) / 8 * 8;

    localparam logic [1:0] ACT_EXEC    = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic REG_START_PC   = 1'b0;
    localparam logic REG_STACK_INIT = 1'b1;

    localparam logic [4:0] GPR_SP = 5'd29;
    localparam logic [4:0] GPR_RA = 5'd31;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_NORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;
    localparam logic [5:0] OP_HALT  = 6'h3F;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_NAND = 6'h28;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    // Encoded as access length in bytes minus one.
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd3
    } msize_t;

    typedef struct packed {
        logic [31:0]       pc_next;
        logic              halt_next;
        logic              reg_we;
        logic [4:0]        reg_dest;
        logic [31:0]       reg_value;
        logic              is_load;
        msize_t            ld_size;
        logic              ld_signed;
        logic [ADDR_W-1:0] rd_base;
        logic              mem_we;
        logic [ADDR_W-1:0] mem_base;
        msize_t            mem_size;
        logic [31:0]       mem_wdata;
        logic [31:0]       mem_value;
    } exec_res_t;

endpackage

>>> hdl/msie_ram.sv
module msie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/msie_dmem.sv
module msie_dmem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        re,
    input  logic [msie_pkg::ADDR_W-1:0] rd_base,
    output logic [31:0]                 rword,
    input  logic                        wr_en,
    input  logic [msie_pkg::ADDR_W-1:0] wr_base,
    input  msie_pkg::msize_t            wr_size,
    input  logic [31:0]                 wr_data,
    output logic                        busy
);

    logic                       clr_busy_reg;
    logic [msie_pkg::ROW_W-1:0] clr_row_reg;
    logic [1:0]                 rd_lo_reg;
    logic [7:0]                 bank_q [4];

    // Byte address x lives in bank x mod 4, row x / 4, so every access of up
    // to four bytes touches each bank at most once.
    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [1:0]                  roff;
        logic [1:0]                  woff;
        logic [1:0]                  wsh;
        logic [msie_pkg::ADDR_W-1:0] raddr_b;
        logic [msie_pkg::ADDR_W-1:0] waddr_b;
        logic [31:0]                 wshift;
        logic                        bwe;
        logic [msie_pkg::ROW_W-1:0]  brow;
        logic [7:0]                  bdata;

        assign roff    = 2'(k) - rd_base[1:0];
        assign raddr_b = rd_base + msie_pkg::ADDR_W'(roff);
        assign woff    = 2'(k) - wr_base[1:0];
        assign waddr_b = wr_base + msie_pkg::ADDR_W'(woff);
        assign wsh     = 2'(wr_size) - woff;
        assign wshift  = wr_data >> {wsh, 3'b000};
        assign bwe     = clr_busy_reg || (wr_en && (woff <= 2'(wr_size)));
        assign brow    = clr_busy_reg ? clr_row_reg
                                      : waddr_b[msie_pkg::ADDR_W-1:2];
        assign bdata   = clr_busy_reg ? 8'h00 : wshift[7:0];

        msie_ram #(
            .WIDTH (8),
            .DEPTH (msie_pkg::ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bwe),
            .waddr (brow),
            .wdata (bdata),
            .re    (re),
            .raddr (raddr_b[msie_pkg::ADDR_W-1:2]),
            .rdata (bank_q[k])
        );

        // Big-endian: the byte at the base address is the most significant.
        assign rword[31-8*k -: 8] = bank_q[rd_lo_reg + 2'(k)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == msie_pkg::ROW_W'(msie_pkg::ROWS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_lo_reg <= rd_base[1:0];
        end
    end

    assign busy = clr_busy_reg;

endmodule

>>> hdl/msie_exec.sv
module msie_exec (
    input  logic [1:0]          action,
    input  logic [31:0]         instr,
    input  logic [7:0]          load_index,
    input  logic [31:0]         load_data,
    input  logic [31:0]         pc,
    input  logic                halt,
    input  logic [31:0]         op_a,
    input  logic [31:0]         op_b,
    input  logic [31:0]         start_pc,
    input  logic [31:0]         stack_init,
    output msie_pkg::exec_res_t res
);

    always_comb
    begin
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] simm;
        logic [31:0] ea;
        logic [31:0] pc4;
        logic [31:0] tgt;
        logic [31:0] ld_addr;
        logic        wr;
        logic [4:0]  wdest;
        logic [31:0] wval;

        op      = instr[31:26];
        rt      = instr[20:16];
        rd      = instr[15:11];
        sh      = instr[10:6];
        fn      = instr[5:0];
        imm     = instr[15:0];
        simm    = {{16{imm[15]}}, imm};
        ea      = op_a + simm;
        pc4     = pc + 32'd4;
        tgt     = pc4 + {simm[29:0], 2'b00};
        ld_addr = {22'd0, load_index, 2'b00};
        wr      = 1'b0;
        wdest   = '0;
        wval    = '0;

        res           = '0;
        res.pc_next   = pc;
        res.halt_next = halt;
        res.ld_size   = msie_pkg::SZ_WORD;
        res.mem_size  = msie_pkg::SZ_WORD;
        res.rd_base   = ea[msie_pkg::ADDR_W-1:0];

        unique case (action)
            msie_pkg::ACT_LOAD:
            begin
                res.mem_we    = 1'b1;
                res.mem_base  = ld_addr[msie_pkg::ADDR_W-1:0];
                res.mem_wdata = load_data;
                res.mem_value = load_data;
            end
            msie_pkg::ACT_RESTART:
            begin
                res.pc_next   = start_pc;
                res.halt_next = 1'b0;
                wr            = 1'b1;
                wdest         = msie_pkg::GPR_SP;
                wval          = stack_init;
            end
            msie_pkg::ACT_EXEC:
            begin
                if (!halt)
                begin
                    res.pc_next = pc4;
                    wdest       = rt;
                    unique case (op)
                        msie_pkg::OP_HALT:
                        begin
                            res.halt_next = 1'b1;
                            res.pc_next   = pc;
                        end
                        msie_pkg::OP_RTYPE:
                        begin
                            wr    = 1'b1;
                            wdest = rd;
                            unique case (fn)
                                msie_pkg::FN_ADD,
                                msie_pkg::FN_ADDU: wval = op_a + op_b;
                                msie_pkg::FN_SUB:  wval = op_a - op_b;
                                msie_pkg::FN_AND:  wval = op_a & op_b;
                                msie_pkg::FN_OR:   wval = op_a | op_b;
                                msie_pkg::FN_XOR:  wval = op_a ^ op_b;
                                msie_pkg::FN_NOR:  wval = ~(op_a | op_b);
                                msie_pkg::FN_NAND: wval = ~(op_a & op_b);
                                msie_pkg::FN_SLT:
                                    wval = {31'd0, $signed(op_a) < $signed(op_b)};
                                msie_pkg::FN_SLL:  wval = op_b << sh;
                                msie_pkg::FN_SRL:  wval = op_b >> sh;
                                msie_pkg::FN_SRA:  wval = $unsigned($signed(op_b) >>> sh);
                                msie_pkg::FN_JR:
                                begin
                                    wr          = 1'b0;
                                    res.pc_next = op_a;
                                end
                                default:           wr = 1'b0;
                            endcase
                        end
                        msie_pkg::OP_J:
                            res.pc_next = {pc4[31:28], instr[25:0], 2'b00};
                        msie_pkg::OP_JAL:
                        begin
                            res.pc_next = {pc4[31:28], instr[25:0], 2'b00};
                            wr          = 1'b1;
                            wdest       = msie_pkg::GPR_RA;
                            wval        = pc4;
                        end
                        msie_pkg::OP_ADDI,
                        msie_pkg::OP_ADDIU:
                        begin
                            wr   = 1'b1;
                            wval = ea;
                        end
                        msie_pkg::OP_LW, msie_pkg::OP_LH, msie_pkg::OP_LHU,
                        msie_pkg::OP_LB, msie_pkg::OP_LBU:
                        begin
                            wr            = 1'b1;
                            res.is_load   = 1'b1;
                            res.ld_signed = (op == msie_pkg::OP_LH) ||
                                            (op == msie_pkg::OP_LB);
                            if (op == msie_pkg::OP_LW)
                            begin
                                res.ld_size = msie_pkg::SZ_WORD;
                            end
                            else if ((op == msie_pkg::OP_LH) || (op == msie_pkg::OP_LHU))
                            begin
                                res.ld_size = msie_pkg::SZ_HALF;
                            end
                            else
                            begin
                                res.ld_size = msie_pkg::SZ_BYTE;
                            end
                        end
                        msie_pkg::OP_SW:
                        begin
                            res.mem_we    = 1'b1;
                            res.mem_base  = ea[msie_pkg::ADDR_W-1:0];
                            res.mem_size  = msie_pkg::SZ_WORD;
                            res.mem_wdata = op_b;
                            res.mem_value = op_b;
                        end
                        msie_pkg::OP_SH:
                        begin
                            res.mem_we    = 1'b1;
                            res.mem_base  = ea[msie_pkg::ADDR_W-1:0];
                            res.mem_size  = msie_pkg::SZ_HALF;
                            res.mem_wdata = op_b;
                            res.mem_value = {16'd0, op_b[15:0]};
                        end
                        msie_pkg::OP_SB:
                        begin
                            res.mem_we    = 1'b1;
                            res.mem_base  = ea[msie_pkg::ADDR_W-1:0];
                            res.mem_size  = msie_pkg::SZ_BYTE;
                            res.mem_wdata = op_b;
                            res.mem_value = {24'd0, op_b[7:0]};
                        end
                        msie_pkg::OP_LUI:
                        begin
                            wr   = 1'b1;
                            wval = {imm, 16'd0};
                        end
                        msie_pkg::OP_ANDI:
                        begin
                            wr   = 1'b1;
                            wval = op_a & {16'd0, imm};
                        end
                        msie_pkg::OP_ORI:
                        begin
                            wr   = 1'b1;
                            wval = op_a | {16'd0, imm};
                        end
                        msie_pkg::OP_NORI:
                        begin
                            wr   = 1'b1;
                            wval = ~(op_a | {16'd0, imm});
                        end
                        msie_pkg::OP_SLTI:
                        begin
                            wr   = 1'b1;
                            wval = {31'd0, $signed(op_a) < $signed(simm)};
                        end
                        msie_pkg::OP_BEQ:
                        begin
                            if (op_a == op_b)
                            begin
                                res.pc_next = tgt;
                            end
                        end
                        msie_pkg::OP_BNE:
                        begin
                            if (op_a != op_b)
                            begin
                                res.pc_next = tgt;
                            end
                        end
                        msie_pkg::OP_BGTZ:
                        begin
                            if (!op_a[31] && (op_a != 32'd0))
                            begin
                                res.pc_next = tgt;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        // Writes to register zero are dropped and not reported.
        if (wr && (wdest != 5'd0))
        begin
            res.reg_we    = 1'b1;
            res.reg_dest  = wdest;
            res.reg_value = wval;
        end
        else
        begin
            res.is_load = 1'b0;
        end
    end

endmodule

>>> hdl/mips_subset_instruction_executor.sv
// Executes one item per clock while the output is not stalled and the data
// memory is not being cleared: an instruction of the supported MIPS subset, a
// data word load, or a restart. An item accepted on s_* passes through the input
// register, the memory read stage and the output register to m_*, and a new item
// is taken every cycle under the same conditions; results of an instruction are
// forwarded to the next ones, so dependent instructions run back to back. After
// reset the data memory is cleared one row of four bytes per cycle, DATA_BYTES/4
// rows (256 for 1024 bytes); s_tready stays low during that pass, while
// configuration writes are accepted at once.
module mips_subset_instruction_executor (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // action[1:0], instr[33:2], load_index[41:34], load_data[73:42]
    input  logic [msie_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pc_out[31:0], halted[32], reg_we[33], reg_dest[38:34], reg_value[70:39],
    // mem_we[71], mem_addr[81:72], mem_value[113:82]
    output logic [msie_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [31:0]                cfg_data
);

    logic        adv;
    logic        acc;
    logic        dmem_busy;
    logic [31:0] in_instr;

    logic [31:0] start_pc_reg;
    logic [31:0] stack_init_reg;
    logic [31:0] pc_reg;
    logic        halt_reg;
    logic [31:0] gpr_vld_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [31:0] s1_instr_reg;
    logic [7:0]  s1_load_index_reg;
    logic [31:0] s1_load_data_reg;
    logic        byp_a_reg;
    logic        byp_b_reg;
    logic [31:0] byp_val_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic [31:0] rf_a_q;
    logic [31:0] rf_b_q;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] raw_a;
    logic [31:0] raw_b;
    logic        s1_fire;
    msie_pkg::exec_res_t ex;

    logic                        s2_valid_reg;
    logic [31:0]                 s2_pc_reg;
    logic                        s2_halt_reg;
    logic                        s2_we_reg;
    logic [4:0]                  s2_dest_reg;
    logic [31:0]                 s2_alu_reg;
    logic                        s2_is_load_reg;
    msie_pkg::msize_t            s2_size_reg;
    logic                        s2_signed_reg;
    logic                        s2_mwe_reg;
    logic [msie_pkg::ADDR_W-1:0] s2_maddr_reg;
    logic [31:0]                 s2_mval_reg;
    logic [31:0]                 dm_word;
    logic [31:0]                 ld_value;
    logic [31:0]                 s2_value;
    logic                        rf_we;

    logic                          m_valid_reg;
    logic [msie_pkg::OUT_RAW_W-1:0] m_data_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && !dmem_busy;
    assign acc      = s_tvalid && s_tready;
    assign in_instr = s_tdata[33:2];
    assign s1_fire  = adv && s1_valid_reg;
    assign rf_we    = adv && s2_valid_reg && s2_we_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg   <= '0;
            stack_init_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                msie_pkg::REG_START_PC:   start_pc_reg   <= cfg_data;
                msie_pkg::REG_STACK_INIT: stack_init_reg <= cfg_data;
            endcase
        end
    end

    // Register file: two copies give two read ports, written identically.
    msie_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_dest_reg),
        .wdata (s2_value),
        .re    (adv),
        .raddr (in_instr[25:21]),
        .rdata (rf_a_q)
    );

    msie_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_dest_reg),
        .wdata (s2_value),
        .re    (adv),
        .raddr (in_instr[20:16]),
        .rdata (rf_b_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpr_vld_reg  <= '0;
            s1_valid_reg <= 1'b0;
            byp_a_reg    <= 1'b0;
            byp_b_reg    <= 1'b0;
            vld_a_reg    <= 1'b0;
            vld_b_reg    <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                gpr_vld_reg[s2_dest_reg] <= 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg <= acc;
                // A write landing in the same edge as the read is caught here.
                byp_a_reg    <= rf_we && (s2_dest_reg == in_instr[25:21]);
                byp_b_reg    <= rf_we && (s2_dest_reg == in_instr[20:16]);
                vld_a_reg    <= gpr_vld_reg[in_instr[25:21]];
                vld_b_reg    <= gpr_vld_reg[in_instr[20:16]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_action_reg     <= s_tdata[1:0];
            s1_instr_reg      <= in_instr;
            s1_load_index_reg <= s_tdata[41:34];
            s1_load_data_reg  <= s_tdata[73:42];
            byp_val_reg       <= s2_value;
        end
    end

    assign raw_a = byp_a_reg ? byp_val_reg : (vld_a_reg ? rf_a_q : 32'd0);
    assign raw_b = byp_b_reg ? byp_val_reg : (vld_b_reg ? rf_b_q : 32'd0);

    // The item in the second stage is always the immediate predecessor.
    assign op_a = (s2_valid_reg && s2_we_reg && (s2_dest_reg == s1_instr_reg[25:21]))
                  ? s2_value : raw_a;
    assign op_b = (s2_valid_reg && s2_we_reg && (s2_dest_reg == s1_instr_reg[20:16]))
                  ? s2_value : raw_b;

    msie_exec u_exec (
        .action     (s1_action_reg),
        .instr      (s1_instr_reg),
        .load_index (s1_load_index_reg),
        .load_data  (s1_load_data_reg),
        .pc         (pc_reg),
        .halt       (halt_reg),
        .op_a       (op_a),
        .op_b       (op_b),
        .start_pc   (start_pc_reg),
        .stack_init (stack_init_reg),
        .res        (ex)
    );

    msie_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .re      (adv),
        .rd_base (ex.rd_base),
        .rword   (dm_word),
        .wr_en   (s1_fire && ex.mem_we),
        .wr_base (ex.mem_base),
        .wr_size (ex.mem_size),
        .wr_data (ex.mem_wdata),
        .busy    (dmem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                pc_reg   <= ex.pc_next;
                halt_reg <= ex.halt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pc_reg      <= ex.pc_next;
            s2_halt_reg    <= ex.halt_next;
            s2_we_reg      <= ex.reg_we;
            s2_dest_reg    <= ex.reg_dest;
            s2_alu_reg     <= ex.reg_value;
            s2_is_load_reg <= ex.is_load;
            s2_size_reg    <= ex.ld_size;
            s2_signed_reg  <= ex.ld_signed;
            s2_mwe_reg     <= ex.mem_we;
            s2_maddr_reg   <= ex.mem_we ? ex.mem_base : '0;
            s2_mval_reg    <= ex.mem_value;
        end
    end

    always_comb
    begin
        unique case (s2_size_reg)
            msie_pkg::SZ_WORD: ld_value = dm_word;
            msie_pkg::SZ_HALF:
                ld_value = {{16{s2_signed_reg & dm_word[31]}}, dm_word[31:16]};
            msie_pkg::SZ_BYTE:
                ld_value = {{24{s2_signed_reg & dm_word[31]}}, dm_word[31:24]};
            default:           ld_value = dm_word;
        endcase
    end

    assign s2_value = s2_is_load_reg ? ld_value : s2_alu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {s2_mval_reg, s2_maddr_reg, s2_mwe_reg, s2_value,
                           s2_dest_reg, s2_we_reg, s2_halt_reg, s2_pc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = msie_pkg::OUT_W'(m_data_reg);

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) dmem_busy |-> !s_tready)
        else $error("item accepted during memory clearing pass");

    a_no_write_to_zero: assert property (
        @(posedge clk) disable iff (!rst_n) rf_we |-> (s2_dest_reg != 5'd0))
        else $error("register zero written");

    a_pc_holds_without_item: assert property (
        @(posedge clk) disable iff (!rst_n) !s1_fire |=> $stable(pc_reg))
        else $error("pc changed without an item");

    a_quiet_fields: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_data_reg[33]) |-> (m_data_reg[38:34] == 5'd0))
        else $error("register destination reported without a write");

endmodule

>>> sim/msie_checker.sv
// Watches the item, result and register-write channels of the executor,
// predicts each result from its own model of the machine state and compares.
module msie_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [msie_pkg::IN_W-1:0]     s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [msie_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            errors,
    output int                            outstanding,
    output int                            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Same bit order as m_tdata: the last member sits in the lowest bits.
    typedef struct packed {
        logic [31:0]                 mem_value;
        logic [msie_pkg::ADDR_W-1:0] mem_addr;
        logic                        mem_we;
        logic [31:0]                 reg_value;
        logic [4:0]                  reg_dest;
        logic                        reg_we;
        logic                        halted;
        logic [31:0]                 pc_out;
    } step_result_t;

    step_result_t expected_results[$];

    logic [31:0] pc_q;
    logic        halt_q;
    logic [31:0] gpr_q [32];
    logic [7:0]  dmem_q [msie_pkg::DATA_BYTES];
    logic [31:0] start_pc_q;
    logic [31:0] stack_init_q;

    initial
    begin
        errors      = 0;
        checked     = 0;
        outstanding = 0;
        pc_q    = '0;
        halt_q  = 1'b0;
        start_pc_q   = '0;
        stack_init_q = '0;
        for (int i = 0; i < 32; i++) gpr_q[i] = '0;
        for (int i = 0; i < msie_pkg::DATA_BYTES; i++) dmem_q[i] = '0;
    end

    // Big-endian access; every byte address wraps on its own.
    function automatic logic [31:0] read_bytes(input logic [31:0] addr, input int n);
        logic [31:0]                 v;
        logic [msie_pkg::ADDR_W-1:0] p;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            p = addr[msie_pkg::ADDR_W-1:0] + i[msie_pkg::ADDR_W-1:0];
            v = {v[23:0], dmem_q[p]};
        end
        return v;
    endfunction

    task automatic write_bytes(input logic [31:0] addr, input logic [31:0] v, input int n);
        logic [msie_pkg::ADDR_W-1:0] p;
        for (int i = 0; i < n; i++)
        begin
            p = addr[msie_pkg::ADDR_W-1:0] + i[msie_pkg::ADDR_W-1:0];
            dmem_q[p] = 8'(v >> (8 * (n - 1 - i)));
        end
    endtask

    task automatic execute_item(input logic [msie_pkg::IN_W-1:0] d, output step_result_t r);
        logic [1:0]  act;
        logic [31:0] ins, a, b, simm, ea, nxt, tgt, wval, imm;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh, wdest;
        logic        wr;
        logic [msie_pkg::ADDR_W-1:0] laddr;
        r   = '0;
        act = d[1:0];
        ins = d[33:2];
        if (act == msie_pkg::ACT_LOAD)
        begin
            laddr = {d[41:34], 2'b00};
            write_bytes(32'(laddr), d[73:42], 4);
            r.mem_we    = 1'b1;
            r.mem_addr  = laddr;
            r.mem_value = d[73:42];
        end
        else if (act == msie_pkg::ACT_RESTART)
        begin
            pc_q                    = start_pc_q;
            gpr_q[msie_pkg::GPR_SP] = stack_init_q;
            halt_q                  = 1'b0;
            r.reg_we                = 1'b1;
            r.reg_dest              = msie_pkg::GPR_SP;
            r.reg_value             = stack_init_q;
        end
        else if (act == msie_pkg::ACT_EXEC && !halt_q)
        begin
            op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
            rd = ins[15:11]; sh = ins[10:6];  fn = ins[5:0];
            imm  = {16'h0, ins[15:0]};
            simm = {{16{ins[15]}}, ins[15:0]};
            a    = gpr_q[rs];
            b    = gpr_q[rt];
            ea   = a + simm;
            nxt  = pc_q + 32'd4;
            wr    = 1'b0;
            wdest = '0;
            wval  = '0;
            if (op == msie_pkg::OP_HALT)
            begin
                halt_q = 1'b1;
                nxt    = pc_q;
            end
            else if (op == msie_pkg::OP_RTYPE)
            begin
                wr    = 1'b1;
                wdest = rd;
                case (fn)
                    msie_pkg::FN_ADD, msie_pkg::FN_ADDU: wval = a + b;
                    msie_pkg::FN_SUB:  wval = a - b;
                    msie_pkg::FN_AND:  wval = a & b;
                    msie_pkg::FN_OR:   wval = a | b;
                    msie_pkg::FN_XOR:  wval = a ^ b;
                    msie_pkg::FN_NOR:  wval = ~(a | b);
                    msie_pkg::FN_NAND: wval = ~(a & b);
                    msie_pkg::FN_SLT:  wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                    msie_pkg::FN_SLL:  wval = b << sh;
                    msie_pkg::FN_SRL:  wval = b >> sh;
                    msie_pkg::FN_SRA:  wval = $signed(b) >>> sh;
                    msie_pkg::FN_JR:
                    begin
                        wr  = 1'b0;
                        nxt = a;
                    end
                    default: wr = 1'b0;
                endcase
            end
            else if (op == msie_pkg::OP_J || op == msie_pkg::OP_JAL)
            begin
                nxt = {nxt[31:28], ins[25:0], 2'b00};
                if (op == msie_pkg::OP_JAL)
                begin
                    wr    = 1'b1;
                    wdest = msie_pkg::GPR_RA;
                    wval  = pc_q + 32'd4;
                end
            end
            else
            begin
                tgt   = pc_q + 32'd4 + (simm << 2);
                wdest = rt;
                case (op)
                    msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU: begin wr = 1'b1; wval = ea; end
                    msie_pkg::OP_LW:  begin wr = 1'b1; wval = read_bytes(ea, 4); end
                    msie_pkg::OP_LH:
                    begin
                        wr   = 1'b1;
                        wval = read_bytes(ea, 2);
                        wval = {{16{wval[15]}}, wval[15:0]};
                    end
                    msie_pkg::OP_LHU: begin wr = 1'b1; wval = read_bytes(ea, 2); end
                    msie_pkg::OP_LB:
                    begin
                        wr   = 1'b1;
                        wval = read_bytes(ea, 1);
                        wval = {{24{wval[7]}}, wval[7:0]};
                    end
                    msie_pkg::OP_LBU: begin wr = 1'b1; wval = read_bytes(ea, 1); end
                    msie_pkg::OP_SW:
                    begin
                        r.mem_we = 1'b1; r.mem_value = b; write_bytes(ea, b, 4);
                    end
                    msie_pkg::OP_SH:
                    begin
                        r.mem_we = 1'b1; r.mem_value = b & 32'hFFFF; write_bytes(ea, b, 2);
                    end
                    msie_pkg::OP_SB:
                    begin
                        r.mem_we = 1'b1; r.mem_value = b & 32'hFF; write_bytes(ea, b, 1);
                    end
                    msie_pkg::OP_LUI:  begin wr = 1'b1; wval = imm << 16; end
                    msie_pkg::OP_ANDI: begin wr = 1'b1; wval = a & imm; end
                    msie_pkg::OP_ORI:  begin wr = 1'b1; wval = a | imm; end
                    msie_pkg::OP_NORI: begin wr = 1'b1; wval = ~(a | imm); end
                    msie_pkg::OP_SLTI:
                    begin
                        wr   = 1'b1;
                        wval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                    end
                    msie_pkg::OP_BEQ:  if (a == b) nxt = tgt;
                    msie_pkg::OP_BNE:  if (a != b) nxt = tgt;
                    msie_pkg::OP_BGTZ: if (!a[31] && a != 0) nxt = tgt;
                    default: ;
                endcase
                if (r.mem_we) r.mem_addr = ea[msie_pkg::ADDR_W-1:0];
            end
            if (wr && wdest != 0)
            begin
                gpr_q[wdest] = wval;
                r.reg_we     = 1'b1;
                r.reg_dest   = wdest;
                r.reg_value  = wval;
            end
            pc_q = nxt;
        end
        r.pc_out = pc_q;
        r.halted = halt_q;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        step_result_t exp_r, act_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                act_r = step_result_t'(m_tdata[$bits(step_result_t)-1:0]);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with nothing expected: %h", $realtime, act_r);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    check_field("pc_out",    exp_r.pc_out,    act_r.pc_out);
                    check_field("halted",    32'(exp_r.halted),   32'(act_r.halted));
                    check_field("reg_we",    32'(exp_r.reg_we),   32'(act_r.reg_we));
                    check_field("reg_dest",  32'(exp_r.reg_dest), 32'(act_r.reg_dest));
                    check_field("reg_value", exp_r.reg_value, act_r.reg_value);
                    check_field("mem_we",    32'(exp_r.mem_we),   32'(act_r.mem_we));
                    check_field("mem_addr",  32'(exp_r.mem_addr), 32'(act_r.mem_addr));
                    check_field("mem_value", exp_r.mem_value, act_r.mem_value);
                end
            end
            if (s_tvalid && s_tready)
            begin
                execute_item(s_tdata, exp_r);
                expected_results.insert(expected_results.size(), exp_r);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == msie_pkg::REG_START_PC)
                    start_pc_q = cfg_data;
                else
                    stack_init_q = cfg_data;
            end
            outstanding = expected_results.size();
        end
    end

endmodule

>>> sim/mips_subset_instruction_executor_tb.sv
module mips_subset_instruction_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [msie_pkg::IN_W-1:0]     s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [msie_pkg::OUT_W-1:0]    m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic                          cfg_index;
    logic [31:0]                   cfg_data;

    int errors, outstanding, checked;
    int burst_left;
    int n_items, n_loads, n_restarts, n_halts;
    int rx_mode, rx_left;

    mips_subset_instruction_executor dut (.*);

    msie_checker checker_i (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .outstanding, .checked
    );

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("mips_subset_instruction_executor verification failed");
        $finish;
    end

    // Receiver: stretches always ready, stretches of random stalls, and stretches of full stalls.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 2) ? $urandom_range(1, 15) : $urandom_range(1, 40);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= 1'b0;
        endcase
    end

    function automatic logic [31:0] r_ins(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {msie_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_ins(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] fns [13];
        logic [5:0] ops [21];
        int         r;
        fns = '{msie_pkg::FN_SLL, msie_pkg::FN_SRL, msie_pkg::FN_SRA, msie_pkg::FN_JR,
                msie_pkg::FN_ADD, msie_pkg::FN_ADDU, msie_pkg::FN_SUB, msie_pkg::FN_AND,
                msie_pkg::FN_OR, msie_pkg::FN_XOR, msie_pkg::FN_NOR, msie_pkg::FN_NAND,
                msie_pkg::FN_SLT};
        ops = '{msie_pkg::OP_J, msie_pkg::OP_JAL, msie_pkg::OP_BEQ, msie_pkg::OP_BNE,
                msie_pkg::OP_BGTZ, msie_pkg::OP_ADDI, msie_pkg::OP_ADDIU,
                msie_pkg::OP_SLTI, msie_pkg::OP_ANDI, msie_pkg::OP_ORI,
                msie_pkg::OP_NORI, msie_pkg::OP_LUI, msie_pkg::OP_LB, msie_pkg::OP_LH,
                msie_pkg::OP_LW, msie_pkg::OP_LBU, msie_pkg::OP_LHU, msie_pkg::OP_SB,
                msie_pkg::OP_SH, msie_pkg::OP_SW, msie_pkg::OP_LUI};
        r = $urandom_range(0, 99);
        if (r < 35)
            return {msie_pkg::OP_RTYPE, 20'($urandom), fns[$urandom_range(0, 12)]};
        else if (r < 38)
            return {msie_pkg::OP_RTYPE, 26'($urandom)};
        else if (r < 97)
            return {ops[$urandom_range(0, 20)], 26'($urandom)};
        else
            return $urandom;
    endfunction

    // Holds s_tvalid high after the handshake; the caller lowers it when idling.
    task automatic send_item(input logic [1:0] act, input logic [31:0] ins,
                             input logic [7:0] idx, input logic [31:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= msie_pkg::IN_W'({data, idx, ins, act});
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        n_items++;
        if (act == msie_pkg::ACT_LOAD) n_loads++;
        if (act == msie_pkg::ACT_RESTART) n_restarts++;
        if (act == msie_pkg::ACT_EXEC && ins[31:26] == msie_pkg::OP_HALT) n_halts++;
    endtask

    task automatic exec(input logic [31:0] ins);
        send_item(msie_pkg::ACT_EXEC, ins, 8'($urandom), $urandom);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers change only once the pipeline has drained.
    task automatic set_registers(input logic [31:0] pc0, input logic [31:0] sp0);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (6) @(negedge clk);
        write_reg(msie_pkg::REG_START_PC, pc0);
        write_reg(msie_pkg::REG_STACK_INIT, sp0);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_items(input int count);
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 999);
            if (r < 860)
                exec(rand_instr());
            else if (r < 930)
                send_item(msie_pkg::ACT_LOAD, $urandom, 8'($urandom), $urandom);
            else if (r < 960)
                send_item(msie_pkg::ACT_RESTART, $urandom, 8'($urandom), $urandom);
            else if (r < 970)
                send_item(ACT_UNUSED, $urandom, 8'($urandom), $urandom);
            else if (r < 980)
                exec({msie_pkg::OP_HALT, 26'($urandom)});
            else
                exec($urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0; rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        cfg_valid = 1'b0; cfg_index = msie_pkg::REG_START_PC; cfg_data = '0;
        burst_left = 0; rx_left = 0; rx_mode = 0;
        n_items = 0; n_loads = 0; n_restarts = 0; n_halts = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_registers(32'h0040_0000, 32'h7FFF_EFFC);
        send_item(msie_pkg::ACT_LOAD, 32'h0, 8'd0, 32'h80FF_7F01);
        send_item(msie_pkg::ACT_LOAD, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
        send_item(msie_pkg::ACT_RESTART, 32'h0, 8'd0, 32'h0);
        exec(i_ins(msie_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
        exec(i_ins(msie_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        exec(i_ins(msie_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
        exec(i_ins(msie_pkg::OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
        exec(r_ins(msie_pkg::FN_ADD, 5'd1, 5'd2, 5'd4, 5'd0));
        exec(r_ins(msie_pkg::FN_SUB, 5'd1, 5'd2, 5'd4, 5'd0));
        exec(r_ins(msie_pkg::FN_NAND, 5'd1, 5'd2, 5'd4, 5'd0));
        exec(r_ins(msie_pkg::FN_SLT, 5'd1, 5'd3, 5'd5, 5'd0));
        exec(r_ins(msie_pkg::FN_SRA, 5'd0, 5'd1, 5'd6, 5'd31));
        exec(r_ins(msie_pkg::FN_SLL, 5'd0, 5'd2, 5'd6, 5'd31));
        exec(i_ins(msie_pkg::OP_SLTI, 5'd1, 5'd7, 16'hFFFF));
        exec(i_ins(msie_pkg::OP_NORI, 5'd3, 5'd7, 16'h00F0));
        // A word load from address -1 wraps from the top byte to the bottom.
        exec(i_ins(msie_pkg::OP_LW, 5'd0, 5'd8, 16'hFFFF));
        exec(i_ins(msie_pkg::OP_LB, 5'd0, 5'd9, 16'h0001));
        exec(i_ins(msie_pkg::OP_LHU, 5'd0, 5'd9, 16'h0001));
        exec(i_ins(msie_pkg::OP_SW, 5'd0, 5'd1, 16'h03FE));
        // A write to register zero is dropped.
        exec(i_ins(msie_pkg::OP_ADDI, 5'd0, 5'd0, 16'h0005));
        exec(i_ins(msie_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
        exec(i_ins(msie_pkg::OP_BGTZ, 5'd3, 5'd0, 16'h0010));
        exec({msie_pkg::OP_JAL, 26'h3FF_FFFF});
        exec(r_ins(msie_pkg::FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
        exec({6'h3E, 26'h155_5555});
        exec(r_ins(6'h3F, 5'd1, 5'd2, 5'd3, 5'd0));
        exec({msie_pkg::OP_HALT, 26'h0});
        exec(i_ins(msie_pkg::OP_ADDI, 5'd0, 5'd4, 16'h1234));
        send_item(msie_pkg::ACT_LOAD, 32'h0, 8'd1, 32'h1234_5678);
        send_item(ACT_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_item(msie_pkg::ACT_RESTART, 32'h0, 8'd0, 32'h0);

        random_items(300);
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(msie_pkg::ACT_RESTART, 32'h0, 8'd0, 32'h0);
        random_items(300);
        set_registers(32'h0, 32'h0);
        random_items(250);
        set_registers($urandom, $urandom);
        random_items(270);

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d items (%0d loads, %0d restarts, %0d halts), checked %0d results.",
                 n_items, n_loads, n_restarts, n_halts, checked);
        if (errors == 0 && outstanding == 0)
            $display("mips_subset_instruction_executor verification clean");
        else
            $display("mips_subset_instruction_executor verification failed");
        $finish;
    end

endmodule
